[rtl/vrs_pkg.sv]
// Shared types and constants for the value run segmenter.
`timescale 1ns / 1ps

package vrs_pkg;

    // Default counter width for sample indexes, lengths and counts.
    localparam int INDEX_BITS_DEF = 32;

    // Width of the index and count fields of a result item.
    localparam int FIELD_BITS = 32;

    // Reset value of the run limit register.
    localparam logic [15:0] MAX_RUNS_RESET = 16'd16;

    // Output buffer depth; an end command can push two items at once.
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;
    localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

    // Input commands.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_END    = 1'b1;

    // Result item kinds.
    localparam logic KIND_RUN     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Summary verdict codes.
    localparam logic [1:0] VERDICT_EMPTY     = 2'd0;
    localparam logic [1:0] VERDICT_TRUNCATED = 2'd1;
    localparam logic [1:0] VERDICT_STATIC    = 2'd2;
    localparam logic [1:0] VERDICT_RUNS      = 2'd3;

    // One input item.
    typedef struct packed {
        logic               cmd;
        logic signed [63:0] sample_value;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic                  item_kind;
        logic signed [63:0]    run_value;
        logic [FIELD_BITS-1:0] run_first_index;
        logic [FIELD_BITS-1:0] run_last_index;
        logic [FIELD_BITS-1:0] run_length;
        logic [FIELD_BITS-1:0] total_samples;
        logic [FIELD_BITS-1:0] total_changes;
        logic                  all_runs_kept;
        logic [1:0]            verdict;
        logic                  final_item;
    } t_out_item;

    // Results produced by one accepted item, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        t_out_item  first;
        t_out_item  second;
    } t_push;

endpackage

[rtl/value_run_segmenter.sv]
// Top level of the value run segmenter.
//
//  Channel   Direction  Handshake                       Payload
//  in        input      i_in_valid / o_in_ready         i_in_item (t_in_item)
//  out       output     o_out_valid / i_out_ready       o_out_item (t_out_item)
//  cfg       input      i_cfg_wr_en, no wait            i_cfg_wr_data (max_runs)
//
// An input item is processed in the cycle it is accepted: one 64-bit compare and
// the counter updates act on the state registers, and results land in a 4-entry
// output buffer, so one item a cycle is taken while the output side drains.
// A run record enters the buffer as its closing item is accepted; an end item
// gives up to two items, one a cycle while i_out_ready is high; input stalls
// while fewer than two entries are free. Reset is synchronous, no clearing pass.
`timescale 1ns / 1ps

module value_run_segmenter #(
    parameter int INDEX_BITS = vrs_pkg::INDEX_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  vrs_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output vrs_pkg::t_out_item o_out_item,
    input  logic               i_cfg_wr_en,
    input  logic [15:0]        i_cfg_wr_data
);
    import vrs_pkg::*;

    logic  accept;
    t_push push;

    assign accept = i_in_valid && o_in_ready;

    // Run tracking and result generation.
    vrs_core #(
        .INDEX_BITS (INDEX_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (i_in_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_push        (push)
    );

    // Result buffer toward the output channel.
    vrs_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

[rtl/vrs_core.sv]
// Run tracking state, counters and result item generation.
`timescale 1ns / 1ps

module vrs_core #(
    parameter int INDEX_BITS = vrs_pkg::INDEX_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  vrs_pkg::t_in_item i_item,
    input  logic             i_cfg_wr_en,
    input  logic [15:0]      i_cfg_wr_data,
    output vrs_pkg::t_push   o_push
);
    import vrs_pkg::*;

    localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};

    logic [15:0]           r_max_runs;
    logic signed [63:0]    r_open_value;
    logic [INDEX_BITS-1:0] r_open_first;
    logic [INDEX_BITS-1:0] r_open_len;
    logic                  r_open_kept;
    logic [INDEX_BITS-1:0] r_samples;
    logic [INDEX_BITS-1:0] r_changes;
    logic [15:0]           r_kept_cnt;
    logic                  r_complete;

    logic                  is_sample;
    logic                  run_open;
    logic                  same_value;
    logic                  start_run;
    logic                  value_change;
    logic                  keep_new;
    logic [INDEX_BITS:0]   last_sum;
    logic [INDEX_BITS-1:0] last_idx;
    logic [INDEX_BITS-1:0] len_inc;
    logic [INDEX_BITS-1:0] samples_inc;
    logic [INDEX_BITS-1:0] changes_inc;
    t_out_item             rec_item;
    t_out_item             sum_item;

    // Fit an index-width value into a result field, truncating or zero-extending.
    function automatic logic [FIELD_BITS-1:0] to_field(input logic [INDEX_BITS-1:0] v);
        logic [INDEX_BITS+FIELD_BITS-1:0] ext;
        ext = {{FIELD_BITS{1'b0}}, v};
        return ext[FIELD_BITS-1:0];
    endfunction

    // Saturating increment at the index maximum.
    function automatic logic [INDEX_BITS-1:0] sat_inc(input logic [INDEX_BITS-1:0] v);
        return (v == IDX_MAX) ? IDX_MAX : v + 1'b1;
    endfunction

    // Item decode against the open run.
    assign is_sample    = (i_item.cmd == CMD_SAMPLE);
    assign run_open     = (r_open_len != '0);
    assign same_value   = (i_item.sample_value == r_open_value);
    assign value_change = run_open && !same_value;
    assign start_run    = !run_open || !same_value;
    assign keep_new     = (r_kept_cnt < r_max_runs);
    assign len_inc      = sat_inc(r_open_len);
    assign samples_inc  = sat_inc(r_samples);
    assign changes_inc  = sat_inc(r_changes);

    // Last index of the open run, clamped to the index maximum.
    assign last_sum = {1'b0, r_open_first} + {1'b0, r_open_len} - 1'b1;
    assign last_idx = last_sum[INDEX_BITS] ? IDX_MAX : last_sum[INDEX_BITS-1:0];

    // Run record for the open run; final only when a sample closes it.
    always_comb begin
        rec_item                 = '0;
        rec_item.item_kind       = KIND_RUN;
        rec_item.run_value       = r_open_value;
        rec_item.run_first_index = to_field(r_open_first);
        rec_item.run_last_index  = to_field(last_idx);
        rec_item.run_length      = to_field(r_open_len);
        rec_item.final_item      = is_sample;
    end

    // End summary for the sequence.
    always_comb begin
        sum_item               = '0;
        sum_item.item_kind     = KIND_SUMMARY;
        sum_item.total_samples = to_field(r_samples);
        sum_item.total_changes = to_field(r_changes);
        sum_item.all_runs_kept = r_complete;
        sum_item.final_item    = 1'b1;
        if (r_samples == '0) begin
            sum_item.verdict = VERDICT_EMPTY;
        end else if (!r_complete) begin
            sum_item.verdict = VERDICT_TRUNCATED;
        end else if (r_changes == '0) begin
            sum_item.verdict = VERDICT_STATIC;
        end else begin
            sum_item.verdict = VERDICT_RUNS;
        end
    end

    // Results pushed for the accepted item.
    always_comb begin
        o_push        = '0;
        o_push.first  = rec_item;
        o_push.second = sum_item;
        if (i_accept) begin
            if (is_sample) begin
                if (value_change && r_open_kept) begin
                    o_push.count = 2'd1;
                end
            end else if (run_open && r_open_kept) begin
                o_push.count = 2'd2;
            end else begin
                o_push.count = 2'd1;
                o_push.first = sum_item;
            end
        end
    end

    // Run limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_runs <= MAX_RUNS_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_runs <= i_cfg_wr_data;
        end
    end

    // Sequence state update on each accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_value <= '0;
            r_open_first <= '0;
            r_open_len   <= '0;
            r_open_kept  <= 1'b0;
            r_samples    <= '0;
            r_changes    <= '0;
            r_kept_cnt   <= '0;
            r_complete   <= 1'b1;
        end else if (i_accept) begin
            if (is_sample) begin
                if (start_run) begin
                    r_open_value <= i_item.sample_value;
                    r_open_first <= r_samples;
                    r_open_len   <= {{(INDEX_BITS-1){1'b0}}, 1'b1};
                    if (keep_new) begin
                        r_open_kept <= 1'b1;
                        r_kept_cnt  <= r_kept_cnt + 1'b1;
                    end else begin
                        r_open_kept <= 1'b0;
                        r_complete  <= 1'b0;
                    end
                end else begin
                    r_open_len <= len_inc;
                end
                if (value_change) begin
                    r_changes <= changes_inc;
                end
                r_samples <= samples_inc;
            end else begin
                r_open_value <= '0;
                r_open_first <= '0;
                r_open_len   <= '0;
                r_open_kept  <= 1'b0;
                r_samples    <= '0;
                r_changes    <= '0;
                r_kept_cnt   <= '0;
                r_complete   <= 1'b1;
            end
        end
    end

endmodule

[rtl/vrs_out_fifo.sv]
// Output buffer: takes up to two result items a cycle, gives one if ready.
`timescale 1ns / 1ps

module vrs_out_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vrs_pkg::t_push     i_push,
    output logic               o_room,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output vrs_pkg::t_out_item o_out_item
);
    import vrs_pkg::*;

    t_out_item                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [FIFO_CNT_BITS-1:0] r_count;

    logic                     pop;
    logic [FIFO_PTR_BITS-1:0] wr_ptr_b;
    logic [FIFO_CNT_BITS-1:0] n_count;

    // Room for the worst case of two items from one input item.
    assign o_room      = (r_count <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
    assign o_out_valid = (r_count != '0);
    assign o_out_item  = r_mem[r_rd_ptr];
    assign pop         = o_out_valid && i_out_ready;
    assign wr_ptr_b    = r_wr_ptr + 1'b1;
    assign n_count     = r_count + FIFO_CNT_BITS'(i_push.count)
                         - FIFO_CNT_BITS'(pop);

    // Entry writes.
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_b] <= i_push.second;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_PTR_BITS'(i_push.count);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

[test/testbench.sv]
// Self-checking testbench for the value run segmenter: directed and random item streams.
`timescale 1ns / 1ps

module testbench;

    import vrs_pkg::*;

    // Cycles to let pass after the last result before a limit write or the end.
    localparam int SETTLE_CYCLES = 4;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;
    logic      i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;

    value_run_segmenter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    // Shadow copy of the run limit and the sequence state.
    logic [15:0] lim_runs;
    logic [63:0] cur_value;
    logic [31:0] cur_first;
    logic [31:0] cur_len;
    bit          cur_kept;
    logic [31:0] seq_samples;
    logic [31:0] seq_changes;
    logic [15:0] seq_kept_runs;
    bit          seq_complete;

    // Run records and summaries still to come, oldest first.
    t_out_item   run_and_summary_q[$];

    int          n_errors;
    int          items_sent;
    bit          quiet;
    int          stall_left;
    logic [63:0] value_pool[8];
    t_out_item   exp_item;

    // Clock with a 10 ns period.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run limit: a generous fixed time well past the slowest correct run.
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Saturating increment of a counter.
    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    // Clear the sequence state, as after reset or an end item.
    function automatic void clear_sequence();
        cur_value     = '0;
        cur_first     = '0;
        cur_len       = '0;
        cur_kept      = 1'b0;
        seq_samples   = '0;
        seq_changes   = '0;
        seq_kept_runs = '0;
        seq_complete  = 1'b1;
    endfunction

    // Open a new run at the current sample index.
    function automatic void open_run(input logic [63:0] v);
        cur_value = v;
        cur_first = seq_samples;
        cur_len   = 32'd1;
        if (seq_kept_runs < lim_runs) begin
            cur_kept      = 1'b1;
            seq_kept_runs = seq_kept_runs + 16'd1;
        end else begin
            cur_kept     = 1'b0;
            seq_complete = 1'b0;
        end
    endfunction

    // Record of the open run; the last index clamps at the counter maximum.
    function automatic t_out_item run_record(input bit last_of_item);
        t_out_item   r;
        logic [32:0] last_sum;
        last_sum          = {1'b0, cur_first} + {1'b0, cur_len} - 33'd1;
        r                 = '0;
        r.item_kind       = KIND_RUN;
        r.run_value       = cur_value;
        r.run_first_index = cur_first;
        r.run_last_index  = last_sum[32] ? '1 : last_sum[31:0];
        r.run_length      = cur_len;
        r.final_item      = last_of_item;
        return r;
    endfunction

    // Apply one accepted item to the shadow state and queue what it causes.
    function automatic void segment_item(input t_in_item it);
        t_out_item s;
        if (it.cmd == CMD_SAMPLE) begin
            if (cur_len == 0) begin
                open_run(it.sample_value);
            end else if (it.sample_value == cur_value) begin
                cur_len = sat_inc(cur_len);
            end else begin
                seq_changes = sat_inc(seq_changes);
                if (cur_kept) begin
                    run_and_summary_q.push_back(run_record(1'b1));
                end
                open_run(it.sample_value);
            end
            seq_samples = sat_inc(seq_samples);
        end else begin
            if (cur_len != 0 && cur_kept) begin
                run_and_summary_q.push_back(run_record(1'b0));
            end
            s               = '0;
            s.item_kind     = KIND_SUMMARY;
            s.total_samples = seq_samples;
            s.total_changes = seq_changes;
            s.all_runs_kept = seq_complete;
            if (seq_samples == 0) begin
                s.verdict = VERDICT_EMPTY;
            end else if (!seq_complete) begin
                s.verdict = VERDICT_TRUNCATED;
            end else if (seq_changes == 0) begin
                s.verdict = VERDICT_STATIC;
            end else begin
                s.verdict = VERDICT_RUNS;
            end
            s.final_item = 1'b1;
            run_and_summary_q.push_back(s);
            clear_sequence();
        end
    endfunction

    // Compare one field of a result item.
    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // Output side: random stall bursts, none once the run goes quiet.
    always @(posedge i_clk) begin
        if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 10);
        end
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Check each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (run_and_summary_q.size() == 0) begin
                $error("unexpected result item: kind %0d", o_out_item.item_kind);
                n_errors++;
            end else begin
                exp_item = run_and_summary_q.pop_front();
                check_field("item_kind", 64'(exp_item.item_kind),
                            64'(o_out_item.item_kind));
                check_field("run_value", exp_item.run_value, o_out_item.run_value);
                check_field("run_first_index", 64'(exp_item.run_first_index),
                            64'(o_out_item.run_first_index));
                check_field("run_last_index", 64'(exp_item.run_last_index),
                            64'(o_out_item.run_last_index));
                check_field("run_length", 64'(exp_item.run_length),
                            64'(o_out_item.run_length));
                check_field("total_samples", 64'(exp_item.total_samples),
                            64'(o_out_item.total_samples));
                check_field("total_changes", 64'(exp_item.total_changes),
                            64'(o_out_item.total_changes));
                check_field("all_runs_kept", 64'(exp_item.all_runs_kept),
                            64'(o_out_item.all_runs_kept));
                check_field("verdict", 64'(exp_item.verdict), 64'(o_out_item.verdict));
                check_field("final_item", 64'(exp_item.final_item),
                            64'(o_out_item.final_item));
            end
        end
    end

    // Send one item, with an optional random gap in front of it.
    task automatic send_item(input logic cmd, input logic [63:0] value);
        t_in_item it;
        it.cmd          = cmd;
        it.sample_value = value;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        segment_item(it);
        items_sent++;
    endtask

    // Hold the input side until every expected result has arrived.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (run_and_summary_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the run limit while the block is idle.
    task automatic write_limit(input logic [15:0] v);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        lim_runs = v;
    endtask

    // An end on an empty sequence, then a one-sample static sequence.
    task automatic test_empty_and_static();
        send_item(CMD_END, 64'd0);
        send_item(CMD_SAMPLE, 64'd5);
        send_item(CMD_END, 64'd0);
    endtask

    // Extreme values in runs; the end item carries a value that must be ignored.
    task automatic test_run_records();
        send_item(CMD_SAMPLE, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(CMD_SAMPLE, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(CMD_SAMPLE, 64'h8000_0000_0000_0000);
        send_item(CMD_SAMPLE, 64'd0);
        send_item(CMD_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_END, 64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    // A zero limit keeps nothing; a limit of one keeps only the first run.
    task automatic test_small_limits();
        write_limit(16'd0);
        send_item(CMD_SAMPLE, 64'd7);
        send_item(CMD_SAMPLE, 64'd8);
        send_item(CMD_END, 64'd0);
        write_limit(16'd1);
        send_item(CMD_SAMPLE, 64'd3);
        send_item(CMD_SAMPLE, 64'd3);
        send_item(CMD_SAMPLE, 64'd4);
        send_item(CMD_SAMPLE, 64'd5);
        send_item(CMD_END, 64'd0);
    endtask

    // The limit changes in the middle of a sequence and applies to later runs.
    task automatic test_mid_sequence_limit();
        write_limit(16'd2);
        send_item(CMD_SAMPLE, 64'd10);
        send_item(CMD_SAMPLE, 64'd11);
        write_limit(16'hFFFF);
        send_item(CMD_SAMPLE, 64'd12);
        send_item(CMD_SAMPLE, 64'd13);
        send_item(CMD_SAMPLE, 64'd10);
        send_item(CMD_END, 64'd0);
    endtask

    // Fill the pool of values that random sequences draw from.
    task automatic refill_pool();
        foreach (value_pool[k]) begin
            case ($urandom_range(0, 4))
                0:       value_pool[k] = 64'h7FFF_FFFF_FFFF_FFFF;
                1:       value_pool[k] = 64'h8000_0000_0000_0000;
                2:       value_pool[k] = 64'($urandom_range(0, 3));
                default: value_pool[k] = {$urandom, $urandom};
            endcase
        end
    endtask

    // One sequence of samples with repeated values, optionally closed by an end.
    task automatic send_sequence(input int len, input bit with_end);
        logic [63:0] v;
        v = {$urandom, $urandom};
        refill_pool();
        for (int k = 0; k < len; k++) begin
            if (k == 0 || $urandom_range(0, 99) >= 55) begin
                if ($urandom_range(0, 9) == 0) begin
                    v = {$urandom, $urandom};
                end else begin
                    v = value_pool[$urandom_range(0, 7)];
                end
            end
            send_item(CMD_SAMPLE, v);
        end
        if (with_end) begin
            send_item(CMD_END, {$urandom, $urandom});
        end
    endtask

    // Pick a run limit, favoring the extremes.
    task automatic pick_limit();
        case ($urandom_range(0, 6))
            0:       write_limit(16'd0);
            1:       write_limit(16'd1);
            2:       write_limit(16'd2);
            3:       write_limit(MAX_RUNS_RESET);
            4:       write_limit(16'hFFFF);
            5:       write_limit(16'($urandom_range(3, 40)));
            default: write_limit(16'($urandom_range(0, 65535)));
        endcase
    endtask

    // Random sequences with occasional limit changes, some of them mid-sequence.
    task automatic test_random_sequences(input int target);
        int len;
        while (items_sent < target) begin
            if ($urandom_range(0, 7) == 0) begin
                pick_limit();
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                              : $urandom_range(0, 30);
            if ($urandom_range(0, 9) == 0) begin
                // Leave the sequence open and change the limit under it.
                send_sequence(len, 1'b0);
                pick_limit();
            end else begin
                send_sequence(len, 1'b1);
            end
        end
    endtask

    // Stimulus in turn, then wait for the last results and report.
    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_item     = '0;
        i_out_ready   = 1'b1;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        n_errors      = 0;
        items_sent    = 0;
        quiet         = 1'b0;
        stall_left    = 0;
        lim_runs      = MAX_RUNS_RESET;
        clear_sequence();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_and_static();
        test_run_records();
        test_small_limits();
        test_mid_sequence_limit();
        test_random_sequences(1600);
        drain();
        quiet = 1'b1;
        test_random_sequences(1825);
        send_item(CMD_END, 64'd0);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/vrs_pkg.sv
rtl/vrs_core.sv
rtl/vrs_out_fifo.sv
rtl/value_run_segmenter.sv
test/testbench.sv
